>>> sv/acdc_pkg.sv
// Shared types, constants and a helper function for the AC/DC input qualifier.
package acdc_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int MAX_CHANNELS     = 8;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE_MASK       = 3'd0;
    localparam logic [2:0] REG_PERIOD_LENGTHS  = 3'd1;
    localparam logic [2:0] REG_TOL_PERCENTS    = 3'd2;
    localparam logic [2:0] REG_PERIODS_REQ     = 3'd3;
    localparam logic [2:0] REG_AC_MIN_HIGH     = 3'd4;
    localparam logic [2:0] REG_DC_LOW_PERCENT  = 3'd5;
    localparam logic [2:0] REG_DC_HIGH_PERCENT = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_MODE_MASK       = 8'h00;
    localparam logic [63:0] RST_PERIOD_LENGTHS  = 64'h0A0A_0A0A_0A0A_0A0A;
    localparam logic [63:0] RST_TOL_PERCENTS    = 64'h0A0A_0A0A_0A0A_0A0A;
    localparam logic [7:0]  RST_PERIODS_REQ     = 8'd3;
    localparam logic [7:0]  RST_AC_MIN_HIGH     = 8'd5;
    localparam logic [6:0]  RST_DC_LOW_PERCENT  = 7'd50;
    localparam logic [6:0]  RST_DC_HIGH_PERCENT = 7'd50;

    // Division by 100 of a 16-bit product: floor(x * 83887 / 2^23) is exact below 91180.
    localparam logic [16:0] RECIP_100       = 17'd83887;
    localparam int          RECIP_SHIFT     = 23;

    // Threshold pipeline depth; the input side holds off this long after a write.
    localparam logic [1:0]  SETTLE_CYCLES   = 2'd3;

    // Per-lane settings, already reduced to the bounds the lane compares against.
    typedef struct packed {
        logic        dc_mode;
        logic [7:0]  period_len;
        logic [7:0]  ac_low_bound;
        logic [10:0] ac_high_bound;
        logic [8:0]  dc_need_high;
        logic [8:0]  dc_need_low;
        logic [7:0]  periods_req;
        logic [7:0]  ac_min_high;
    } lane_cfg_t;

    // What one lane reports after a tick.
    typedef struct packed {
        logic level;
        logic fault;
        logic changed;
    } lane_out_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

>>> sv/acdc_thresh.sv
// Per-lane threshold pipeline: tolerance window and DC share limits from configuration.
module acdc_thresh (
    input  logic        aclk,
    input  logic [7:0]  period_len,
    input  logic [7:0]  tol_percent,
    input  logic [6:0]  dc_high_percent,
    input  logic [6:0]  dc_low_percent,
    output logic [7:0]  ac_low_bound,
    output logic [10:0] ac_high_bound,
    output logic [8:0]  dc_need_high,
    output logic [8:0]  dc_need_low
);

    logic [15:0] p_tol_reg, p_nh_reg, p_nl_reg;
    logic [7:0]  len1_reg, len2_reg;
    logic [32:0] q_tol_reg, q_nh_reg, q_nl_reg;
    logic [9:0]  tol;
    logic [7:0]  low_b_reg;
    logic [10:0] high_b_reg;
    logic [8:0]  nh_reg, nl_reg;

    assign tol = q_tol_reg[acdc_pkg::RECIP_SHIFT +: 10];

    // Stage 1: length times percent. Stage 2: times reciprocal of 100.
    // Stage 3: window bounds and DC limits.
    always_ff @(posedge aclk) begin
        p_tol_reg  <= {8'd0, period_len} * {8'd0, tol_percent};
        p_nh_reg   <= {8'd0, period_len} * {9'd0, dc_high_percent};
        p_nl_reg   <= {8'd0, period_len} * {9'd0, dc_low_percent};
        len1_reg   <= period_len;
        q_tol_reg  <= {17'd0, p_tol_reg} * {16'd0, acdc_pkg::RECIP_100};
        q_nh_reg   <= {17'd0, p_nh_reg} * {16'd0, acdc_pkg::RECIP_100};
        q_nl_reg   <= {17'd0, p_nl_reg} * {16'd0, acdc_pkg::RECIP_100};
        len2_reg   <= len1_reg;
        low_b_reg  <= (tol > {2'd0, len2_reg}) ? 8'd0 : 8'({2'd0, len2_reg} - tol);
        high_b_reg <= {3'd0, len2_reg} + {1'b0, tol};
        nh_reg     <= q_nh_reg[acdc_pkg::RECIP_SHIFT +: 9];
        nl_reg     <= q_nl_reg[acdc_pkg::RECIP_SHIFT +: 9];
    end

    assign ac_low_bound  = low_b_reg;
    assign ac_high_bound = high_b_reg;
    assign dc_need_high  = nh_reg;
    assign dc_need_low   = nl_reg;

endmodule

>>> sv/acdc_lane.sv
// One qualifier lane: capture counters, period evaluation and level decision.
module acdc_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  pin,
    input  acdc_pkg::lane_cfg_t   cfg,
    output acdc_pkg::lane_out_t   result
);

    logic       level_reg, level_next;
    logic       fault_reg, fault_next;
    logic       cap_reg, cap_next;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] high_reg, high_next;
    logic [7:0] per_reg, per_next;
    logic [7:0] pass_reg, pass_next;
    logic [7:0] fail_reg, fail_next;
    logic       changed;

    logic       expect_lvl;
    logic [7:0] tick_s, low_s, high_s;
    logic [7:0] per_c, pass_c, fail_c;
    logic       period_end;
    logic       decide;
    logic       abort;
    logic [8:0] total;
    logic [7:0] need_pass;
    logic [8:0] dc_need;
    logic [7:0] dc_got;

    assign expect_lvl = ~level_reg;
    assign tick_s     = acdc_pkg::sat_inc(tick_reg);
    assign high_s     = pin ? acdc_pkg::sat_inc(high_reg) : high_reg;
    assign low_s      = pin ? low_reg : acdc_pkg::sat_inc(low_reg);
    assign period_end = (tick_s >= cfg.period_len);
    assign total      = expect_lvl ? ({1'b0, low_s} + {1'b0, high_s}) : {1'b0, low_s};
    assign need_pass  = (cfg.periods_req == 8'd0) ? 8'd0 : cfg.periods_req - 8'd1;
    assign dc_need    = expect_lvl ? cfg.dc_need_high : cfg.dc_need_low;
    assign dc_got     = expect_lvl ? high_s : low_s;

    always_comb begin
        level_next = level_reg;
        fault_next = fault_reg;
        cap_next   = cap_reg;
        tick_next  = tick_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        per_next   = per_reg;
        pass_next  = pass_reg;
        fail_next  = fail_reg;
        changed    = 1'b0;
        per_c      = per_reg;
        pass_c     = pass_reg;
        fail_c     = fail_reg;
        decide     = 1'b1;
        abort      = 1'b0;
        if (step) begin
            if (!cap_reg) begin
                if (pin == expect_lvl) begin
                    cap_next  = 1'b1;
                    tick_next = tick_s;
                    low_next  = low_s;
                    high_next = high_s;
                end
            end else begin
                tick_next = tick_s;
                low_next  = low_s;
                high_next = high_s;
                if (period_end) begin
                    per_c = acdc_pkg::sat_inc(per_reg);
                    if (!cfg.dc_mode) begin
                        if (expect_lvl && (low_s == 8'd0 || high_s < cfg.ac_min_high)) begin
                            // A pulse input without both levels or enough highs fails; decide on a later tick.
                            fail_c = acdc_pkg::sat_inc(fail_reg);
                            decide = 1'b0;
                        end else if (!expect_lvl && high_s != 8'd0) begin
                            abort = 1'b1;
                        end else if ({2'd0, total} >= {3'd0, cfg.ac_low_bound} &&
                                     {2'd0, total} <= cfg.ac_high_bound) begin
                            pass_c = acdc_pkg::sat_inc(pass_reg);
                        end else begin
                            fail_c = acdc_pkg::sat_inc(fail_reg);
                        end
                    end else if ({1'b0, dc_got} >= dc_need) begin
                        pass_c = acdc_pkg::sat_inc(pass_reg);
                    end
                    tick_next = 8'd0;
                    low_next  = 8'd0;
                    high_next = 8'd0;
                end
                per_next  = per_c;
                pass_next = pass_c;
                fail_next = fail_c;
                if (abort || (decide && per_c >= cfg.periods_req)) begin
                    if (!abort) begin
                        if (pass_c >= need_pass) begin
                            fault_next = 1'b0;
                            level_next = expect_lvl;
                            changed    = 1'b1;
                        end else if (fail_c >= cfg.periods_req) begin
                            fault_next = 1'b1;
                        end
                    end
                    cap_next  = 1'b0;
                    tick_next = 8'd0;
                    low_next  = 8'd0;
                    high_next = 8'd0;
                    per_next  = 8'd0;
                    pass_next = 8'd0;
                    fail_next = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            fault_reg <= 1'b0;
            cap_reg   <= 1'b0;
            tick_reg  <= 8'd0;
            low_reg   <= 8'd0;
            high_reg  <= 8'd0;
            per_reg   <= 8'd0;
            pass_reg  <= 8'd0;
            fail_reg  <= 8'd0;
        end else begin
            level_reg <= level_next;
            fault_reg <= fault_next;
            cap_reg   <= cap_next;
            tick_reg  <= tick_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            per_reg   <= per_next;
            pass_reg  <= pass_next;
            fail_reg  <= fail_next;
        end
    end

    assign result.level   = level_next;
    assign result.fault   = fault_next;
    assign result.changed = changed;

endmodule

>>> sv/acdc_merge.sv
// Merging stage: gathers the lane results into level, error and change masks.
module acdc_merge #(
    parameter int CHANNELS = acdc_pkg::CHANNELS_DEFAULT
) (
    input  acdc_pkg::lane_out_t lanes [CHANNELS],
    output logic [7:0]          level_mask,
    output logic [7:0]          error_mask,
    output logic [7:0]          changed_mask
);

    always_comb begin
        level_mask   = 8'd0;
        error_mask   = 8'd0;
        changed_mask = 8'd0;
        for (int i = 0; i < CHANNELS; i++) begin
            level_mask[i]   = lanes[i].level;
            error_mask[i]   = lanes[i].fault;
            changed_mask[i] = lanes[i].changed;
        end
    end

endmodule

>>> sv/ac_dc_input_qualifier_core.sv
// Top level of the AC/DC input qualifier: configuration, lanes and output register.
//
//  Channel   Direction  Beat contents (low bit first)
//  s_axis    in         tdata: pin_levels[7:0]
//  m_axis    out        tdata: level_mask[7:0], error_mask[15:8], changed_mask[23:16]
//  cfg       in         cfg_index selects the register, cfg_data carries the value
//
// For every scan tick beat, one lane per channel updates its counters and decision in
// parallel, so a new beat is taken each cycle while the output register is empty or
// being drained and no hold-off runs. The result appears on m_axis in the cycle after
// the input beat is accepted. After reset and after each configuration write the input
// side holds s_tready low while the threshold pipeline (two multiplies and the window
// bounds) settles. A stalled output stalls the input; nothing is dropped.
module ac_dc_input_qualifier_core #(
    parameter int CHANNELS = acdc_pkg::CHANNELS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] pin_levels

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [7:0] level_mask, [15:8] error_mask,
                                      // [23:16] changed_mask

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Configuration registers.
    logic [7:0]  mode_mask_reg;
    logic [63:0] period_lengths_reg;
    logic [63:0] tol_percents_reg;
    logic [7:0]  periods_req_reg;
    logic [7:0]  ac_min_high_reg;
    logic [6:0]  dc_low_pct_reg;
    logic [6:0]  dc_high_pct_reg;

    // Hold-off counter that covers the threshold pipeline latency.
    logic [1:0]  settle_reg, settle_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg;

    logic        cfg_write;
    logic        s_accept;

    acdc_pkg::lane_cfg_t lane_cfg [CHANNELS];
    acdc_pkg::lane_out_t lane_res [CHANNELS];

    logic [7:0]  level_mask;
    logic [7:0]  error_mask;
    logic [7:0]  changed_mask;

    // The register file is always ready; the user must write only while the block is idle; it does not enforce this.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_mask_reg      <= acdc_pkg::RST_MODE_MASK;
            period_lengths_reg <= acdc_pkg::RST_PERIOD_LENGTHS;
            tol_percents_reg   <= acdc_pkg::RST_TOL_PERCENTS;
            periods_req_reg    <= acdc_pkg::RST_PERIODS_REQ;
            ac_min_high_reg    <= acdc_pkg::RST_AC_MIN_HIGH;
            dc_low_pct_reg     <= acdc_pkg::RST_DC_LOW_PERCENT;
            dc_high_pct_reg    <= acdc_pkg::RST_DC_HIGH_PERCENT;
        end else if (cfg_write) begin
            case (cfg_index)
                acdc_pkg::REG_MODE_MASK:       mode_mask_reg      <= cfg_data[7:0];
                acdc_pkg::REG_PERIOD_LENGTHS:  period_lengths_reg <= cfg_data;
                acdc_pkg::REG_TOL_PERCENTS:    tol_percents_reg   <= cfg_data;
                acdc_pkg::REG_PERIODS_REQ:     periods_req_reg    <= cfg_data[7:0];
                acdc_pkg::REG_AC_MIN_HIGH:     ac_min_high_reg    <= cfg_data[7:0];
                acdc_pkg::REG_DC_LOW_PERCENT:  dc_low_pct_reg     <= cfg_data[6:0];
                acdc_pkg::REG_DC_HIGH_PERCENT: dc_high_pct_reg    <= cfg_data[6:0];
                default: begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    // Any write restarts the hold-off so the lanes never see stale thresholds.
    always_comb begin
        settle_next = settle_reg;
        if (cfg_write) begin
            settle_next = acdc_pkg::SETTLE_CYCLES;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end
    end

    // A beat is taken when the thresholds are settled and the output slot is free
    // or draining in this same cycle.
    assign s_tready = (settle_reg == 2'd0) && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid & s_tready;

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            logic [7:0]  lo_b;
            logic [10:0] hi_b;
            logic [8:0]  need_h;
            logic [8:0]  need_l;

            acdc_thresh u_thresh (
                .aclk            (aclk),
                .period_len      (period_lengths_reg[8*g +: 8]),
                .tol_percent     (tol_percents_reg[8*g +: 8]),
                .dc_high_percent (dc_high_pct_reg),
                .dc_low_percent  (dc_low_pct_reg),
                .ac_low_bound    (lo_b),
                .ac_high_bound   (hi_b),
                .dc_need_high    (need_h),
                .dc_need_low     (need_l)
            );

            assign lane_cfg[g].dc_mode       = mode_mask_reg[g];
            assign lane_cfg[g].period_len    = period_lengths_reg[8*g +: 8];
            assign lane_cfg[g].ac_low_bound  = lo_b;
            assign lane_cfg[g].ac_high_bound = hi_b;
            assign lane_cfg[g].dc_need_high  = need_h;
            assign lane_cfg[g].dc_need_low   = need_l;
            assign lane_cfg[g].periods_req   = periods_req_reg;
            assign lane_cfg[g].ac_min_high   = ac_min_high_reg;

            acdc_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .step    (s_accept),
                .pin     (s_tdata[g]),
                .cfg     (lane_cfg[g]),
                .result  (lane_res[g])
            );
        end
    endgenerate

    acdc_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .lanes        (lane_res),
        .level_mask   (level_mask),
        .error_mask   (error_mask),
        .changed_mask (changed_mask)
    );

    // Output register: loads on every accepted beat, clears once the result is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg   <= acdc_pkg::SETTLE_CYCLES;
            m_tvalid_reg <= 1'b0;
        end else begin
            settle_reg   <= settle_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {changed_mask, error_mask, level_mask};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> bench/ac_dc_input_qualifier_core_tb.sv
// Self-checking testbench for the AC/DC input qualifier core: directed table, then random scans.
module ac_dc_input_qualifier_core_tb;

    // Index 7 has no register behind it; a write there must change nothing.
    localparam logic [2:0] REG_SPARE   = 3'd7;
    // Cycles without any beat on any channel before the run is declared hung.
    localparam int         QUIET_LIMIT = 2000;
    // Extra cycles after the last result, well past the output register and the
    // settle hold-off that follows a configuration write.
    localparam int         DRAIN_PAD   = 8;
    // Length of the one long output stall that backs the block up into its input.
    localparam int         LONG_HOLD   = 80;
    localparam int         HOLD_AFTER  = 150;

    typedef struct packed {
        logic [7:0] level_mask;
        logic [7:0] error_mask;
        logic [7:0] changed_mask;
    } tick_result_t;

    // One row of the directed table: either a register write or a scan tick. A tick
    // carries its result only where it is obvious; otherwise the predictor decides.
    typedef struct packed {
        logic         is_write;
        logic [2:0]   reg_idx;
        logic [63:0]  reg_val;
        logic [7:0]   pins;
        logic         typed;
        tick_result_t typed_val;
    } scan_step_t;

    typedef enum int {WAVE_LOW, WAVE_HIGH, WAVE_PULSE, WAVE_NOISE} wave_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    ac_dc_input_qualifier_core #(
        .CHANNELS (8)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the configuration registers as the block should hold them.
    bit [7:0]  cfg_dc_mask;
    bit [63:0] cfg_period_len;
    bit [63:0] cfg_tol_pct;
    bit [7:0]  cfg_periods_req;
    bit [7:0]  cfg_min_high;
    bit [6:0]  cfg_dc_low_pct;
    bit [6:0]  cfg_dc_high_pct;

    // Predicted per-channel qualifier state.
    bit [7:0] cur_level;
    bit [7:0] cur_fault;
    bit [7:0] in_capture;
    bit [7:0] tick_cnt   [8];
    bit [7:0] low_cnt    [8];
    bit [7:0] high_cnt   [8];
    bit [7:0] period_cnt [8];
    bit [7:0] pass_cnt   [8];
    bit [7:0] fail_cnt   [8];

    // Per-channel waveform generator for the random part.
    wave_t seg_kind [8];
    int    seg_left [8];
    int    seg_pos  [8];
    int    hi_run   [8];
    int    lo_run   [8];

    tick_result_t expected_masks [$];
    scan_step_t   directed_steps [$];

    int error_count;
    int results_seen;
    int quiet_cycles;
    int stall_pct;
    bit long_hold_done;

    function automatic bit [7:0] sat_step(input bit [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic void restart_window(input int ch);
        tick_cnt[ch] = 8'd0;
        low_cnt[ch]  = 8'd0;
        high_cnt[ch] = 8'd0;
    endfunction

    function automatic void abandon_capture(input int ch);
        restart_window(ch);
        period_cnt[ch] = 8'd0;
        pass_cnt[ch]   = 8'd0;
        fail_cnt[ch]   = 8'd0;
        in_capture[ch] = 1'b0;
    endfunction

    function automatic void take_sample(input int ch, input bit pin);
        if (pin) begin
            high_cnt[ch] = sat_step(high_cnt[ch]);
        end else begin
            low_cnt[ch] = sat_step(low_cnt[ch]);
        end
        tick_cnt[ch] = sat_step(tick_cnt[ch]);
    endfunction

    // Advances one channel by one scan tick; returns 1 when its accepted level flips.
    function automatic bit qualify_channel(input int ch, input bit pin);
        bit          want;
        int unsigned len;
        int unsigned total;
        int unsigned tol;
        int unsigned lo;
        int unsigned hi;
        int unsigned pct;
        int unsigned need;
        int unsigned got;
        int unsigned need_pass;
        want = ~cur_level[ch];
        len  = 32'(cfg_period_len[8*ch +: 8]);

        // An idle channel only wakes up on a sample of the opposite level.
        if (!in_capture[ch]) begin
            if (pin == want) begin
                in_capture[ch] = 1'b1;
                take_sample(ch, pin);
            end
            return 1'b0;
        end

        take_sample(ch, pin);

        if (tick_cnt[ch] >= len) begin
            period_cnt[ch] = sat_step(period_cnt[ch]);
            if (!cfg_dc_mask[ch]) begin
                // A rising AC input needs real pulses; a failed period postpones the
                // decision to a later tick.
                if (want && (low_cnt[ch] == 0 || high_cnt[ch] < cfg_min_high)) begin
                    fail_cnt[ch] = sat_step(fail_cnt[ch]);
                    restart_window(ch);
                    return 1'b0;
                end
                // Any pulse while waiting for the input to die out cancels the capture.
                if (!want && high_cnt[ch] != 0) begin
                    abandon_capture(ch);
                    return 1'b0;
                end
                total = want ? 32'(low_cnt[ch]) + 32'(high_cnt[ch]) : 32'(low_cnt[ch]);
                tol   = len * 32'(cfg_tol_pct[8*ch +: 8]) / 100;
                lo    = (tol > len) ? 0 : len - tol;
                hi    = len + tol;
                if (total >= lo && total <= hi) begin
                    pass_cnt[ch] = sat_step(pass_cnt[ch]);
                end else begin
                    fail_cnt[ch] = sat_step(fail_cnt[ch]);
                end
            end else begin
                pct  = want ? 32'(cfg_dc_high_pct) : 32'(cfg_dc_low_pct);
                need = len * pct / 100;
                got  = want ? 32'(high_cnt[ch]) : 32'(low_cnt[ch]);
                if (got >= need) begin
                    pass_cnt[ch] = sat_step(pass_cnt[ch]);
                end
            end
            restart_window(ch);
        end

        if (period_cnt[ch] >= cfg_periods_req) begin
            need_pass = (cfg_periods_req == 0) ? 0 : 32'(cfg_periods_req) - 1;
            if (pass_cnt[ch] >= need_pass) begin
                cur_fault[ch] = 1'b0;
                cur_level[ch] = want;
                abandon_capture(ch);
                return 1'b1;
            end else if (fail_cnt[ch] >= cfg_periods_req) begin
                cur_fault[ch] = 1'b1;
            end
            abandon_capture(ch);
        end
        return 1'b0;
    endfunction

    function automatic tick_result_t qualify_tick(input bit [7:0] pins);
        tick_result_t r;
        r = '0;
        for (int ch = 0; ch < 8; ch++) begin
            r.changed_mask[ch] = qualify_channel(ch, pins[ch]);
        end
        r.level_mask = cur_level;
        r.error_mask = cur_fault;
        return r;
    endfunction

    // Mostly clean waveforms (steady levels and pulse trains) so that captures run all
    // the way to a decision, with stretches of noise mixed in.
    function automatic bit [7:0] next_scan_pins();
        bit [7:0] pins;
        int       pick;
        for (int ch = 0; ch < 8; ch++) begin
            if (seg_left[ch] <= 0) begin
                pick = $urandom_range(0, 9);
                seg_kind[ch] = (pick < 2) ? WAVE_LOW : (pick < 4) ? WAVE_HIGH :
                               (pick < 8) ? WAVE_PULSE : WAVE_NOISE;
                seg_left[ch] = $urandom_range(8, 60);
                hi_run[ch]   = $urandom_range(1, 6);
                lo_run[ch]   = $urandom_range(1, 6);
                seg_pos[ch]  = 0;
            end
            seg_left[ch]--;
            case (seg_kind[ch])
                WAVE_LOW:   pins[ch] = 1'b0;
                WAVE_HIGH:  pins[ch] = 1'b1;
                WAVE_PULSE: begin
                    pins[ch]    = (seg_pos[ch] < hi_run[ch]);
                    seg_pos[ch] = (seg_pos[ch] + 1) % (hi_run[ch] + lo_run[ch]);
                end
                default:    pins[ch] = 1'($urandom_range(0, 1));
            endcase
        end
        return pins;
    endfunction

    function automatic bit [63:0] rand_bytes(input int lo, input int hi);
        bit [63:0] w;
        for (int b = 0; b < 8; b++) begin
            w[8*b +: 8] = 8'($urandom_range(lo, hi));
        end
        return w;
    endfunction

    function automatic scan_step_t write_row(input logic [2:0] idx, input logic [63:0] val);
        scan_step_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        return row;
    endfunction

    function automatic scan_step_t tick_row(input logic [7:0] pins);
        scan_step_t row;
        row      = '0;
        row.pins = pins;
        return row;
    endfunction

    function automatic scan_step_t known_row(input logic [7:0] pins, input logic [7:0] lvl,
                                             input logic [7:0] err, input logic [7:0] chg);
        scan_step_t row;
        row           = '0;
        row.pins      = pins;
        row.typed     = 1'b1;
        row.typed_val = '{level_mask: lvl, error_mask: err, changed_mask: chg};
        return row;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            flag_error($sformatf("result %0d %s: got %02h, expected %02h",
                                 results_seen, name, got, want));
        end
    endtask

    // Offers one scan beat, optionally after an idle burst, and records its expected
    // result once the block takes it. tvalid stays high afterward so back-to-back
    // beats never drop it within a time step.
    task automatic offer_tick(input logic [7:0] pins, input logic typed,
                              input tick_result_t typed_val);
        tick_result_t predicted;
        if ($urandom_range(0, 99) < stall_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pins;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = qualify_tick(pins);
        expected_masks.push_back(typed ? typed_val : predicted);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            acdc_pkg::REG_MODE_MASK:       cfg_dc_mask     = val[7:0];
            acdc_pkg::REG_PERIOD_LENGTHS:  cfg_period_len  = val;
            acdc_pkg::REG_TOL_PERCENTS:    cfg_tol_pct     = val;
            acdc_pkg::REG_PERIODS_REQ:     cfg_periods_req = val[7:0];
            acdc_pkg::REG_AC_MIN_HIGH:     cfg_min_high    = val[7:0];
            acdc_pkg::REG_DC_LOW_PERCENT:  cfg_dc_low_pct  = val[6:0];
            acdc_pkg::REG_DC_HIGH_PERCENT: cfg_dc_high_pct = val[6:0];
            default: ;
        endcase
    endtask

    // Stops offering and waits for every outstanding result, then a short pad so the
    // block is fully idle before the next register write or the end of the run.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_masks.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: checks each accepted beat against the oldest expectation and throttles
    // tready in random bursts, plus one long hold that backs the block up.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                tick_result_t want;
                results_seen++;
                if (expected_masks.size() == 0) begin
                    flag_error($sformatf("result %06h arrived with nothing expected", m_tdata));
                end else begin
                    want = expected_masks.pop_front();
                    compare_field("level_mask",   m_tdata[7:0],   want.level_mask);
                    compare_field("error_mask",   m_tdata[15:8],  want.error_mask);
                    compare_field("changed_mask", m_tdata[23:16], want.changed_mask);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                hold_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles with no beat on any channel means the block hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TIMEOUT: no beat for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int phase_items [5];
        phase_items = '{120, 120, 300, 100, 90};

        error_count    = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        stall_pct      = 20;
        long_hold_done = 1'b0;

        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= acdc_pkg::REG_MODE_MASK;
        cfg_data  <= 64'd0;
        aresetn   <= 1'b0;

        // Predictor starts from the reset state of the block.
        cfg_dc_mask     = acdc_pkg::RST_MODE_MASK;
        cfg_period_len  = acdc_pkg::RST_PERIOD_LENGTHS;
        cfg_tol_pct     = acdc_pkg::RST_TOL_PERCENTS;
        cfg_periods_req = acdc_pkg::RST_PERIODS_REQ;
        cfg_min_high    = acdc_pkg::RST_AC_MIN_HIGH;
        cfg_dc_low_pct  = acdc_pkg::RST_DC_LOW_PERCENT;
        cfg_dc_high_pct = acdc_pkg::RST_DC_HIGH_PERCENT;
        cur_level       = '0;
        cur_fault       = '0;
        for (int ch = 0; ch < 8; ch++) begin
            abandon_capture(ch);
            seg_left[ch] = 0;
        end

        // Directed table. Right after reset every channel is idle and low, so an all-low
        // tick does nothing and an all-high tick only starts captures.
        directed_steps.push_back(known_row(8'h00, 8'h00, 8'h00, 8'h00));
        directed_steps.push_back(known_row(8'hFF, 8'h00, 8'h00, 8'h00));
        directed_steps.push_back(tick_row(8'h00));
        // Zero periods required together with zero period length: decisions come on the
        // first captured tick after the start, unless a rising AC period fails.
        directed_steps.push_back(write_row(acdc_pkg::REG_PERIODS_REQ, 64'd0));
        directed_steps.push_back(write_row(acdc_pkg::REG_PERIOD_LENGTHS, 64'd0));
        directed_steps.push_back(tick_row(8'h00));
        directed_steps.push_back(tick_row(8'h00));
        directed_steps.push_back(tick_row(8'hFF));
        directed_steps.push_back(tick_row(8'hFF));
        directed_steps.push_back(tick_row(8'h55));
        directed_steps.push_back(tick_row(8'hAA));
        // All channels in DC mode with the share thresholds at their extremes and a mix
        // of period lengths, the longest among them.
        directed_steps.push_back(write_row(acdc_pkg::REG_MODE_MASK, 64'hFF));
        directed_steps.push_back(write_row(acdc_pkg::REG_PERIODS_REQ, 64'd1));
        directed_steps.push_back(write_row(acdc_pkg::REG_PERIOD_LENGTHS,
                                           64'h0001_02FF_0304_0506));
        directed_steps.push_back(write_row(acdc_pkg::REG_DC_HIGH_PERCENT, 64'd100));
        directed_steps.push_back(write_row(acdc_pkg::REG_DC_LOW_PERCENT, 64'd0));
        directed_steps.push_back(tick_row(8'hFF));
        directed_steps.push_back(tick_row(8'hFF));
        directed_steps.push_back(tick_row(8'h00));
        directed_steps.push_back(tick_row(8'h00));
        directed_steps.push_back(tick_row(8'h0F));
        directed_steps.push_back(tick_row(8'hF0));
        // Back to AC with tolerances from zero to well past one hundred percent, an
        // unreachable minimum high count, and a write to the unused index.
        directed_steps.push_back(write_row(acdc_pkg::REG_MODE_MASK, 64'h00));
        directed_steps.push_back(write_row(acdc_pkg::REG_TOL_PERCENTS,
                                           64'hFFC8_6564_320A_0100));
        directed_steps.push_back(write_row(acdc_pkg::REG_AC_MIN_HIGH, 64'hFF));
        directed_steps.push_back(write_row(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_steps.push_back(tick_row(8'h01));
        directed_steps.push_back(tick_row(8'h80));
        directed_steps.push_back(tick_row(8'hFE));
        directed_steps.push_back(tick_row(8'h7F));
        directed_steps.push_back(write_row(acdc_pkg::REG_AC_MIN_HIGH, 64'h00));
        directed_steps.push_back(write_row(acdc_pkg::REG_PERIODS_REQ, 64'd2));
        directed_steps.push_back(tick_row(8'h00));
        directed_steps.push_back(tick_row(8'hFF));
        directed_steps.push_back(tick_row(8'h00));
        directed_steps.push_back(tick_row(8'hFF));
        directed_steps.push_back(tick_row(8'h00));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < directed_steps.size(); k++) begin
            if (directed_steps[k].is_write) begin
                if (k == 0 || !directed_steps[k-1].is_write) begin
                    drain_results();
                end
                write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
            end else begin
                if (k > 0 && directed_steps[k-1].is_write) begin
                    cfg_valid <= 1'b0;
                end
                offer_tick(directed_steps[k].pins, directed_steps[k].typed,
                           directed_steps[k].typed_val);
            end
        end

        // Random phases. Each starts from an idle block with a fresh setting:
        //   0 - reset values again
        //   1 - short periods, mixed modes, moderate tolerances
        //   2 - one-tick periods with 255 periods required, so the period and fail
        //       counters run into saturation
        //   3 - extremes: longest and shortest periods, full tolerance, unreachable AC minimum
        //   4 - mixed again, with no idling on either side to close the run
        for (int p = 0; p < 5; p++) begin
            drain_results();
            case (p)
                0: begin
                    stall_pct = 20;
                    write_reg(acdc_pkg::REG_MODE_MASK, 64'(acdc_pkg::RST_MODE_MASK));
                    write_reg(acdc_pkg::REG_PERIOD_LENGTHS, acdc_pkg::RST_PERIOD_LENGTHS);
                    write_reg(acdc_pkg::REG_TOL_PERCENTS, acdc_pkg::RST_TOL_PERCENTS);
                    write_reg(acdc_pkg::REG_PERIODS_REQ, 64'(acdc_pkg::RST_PERIODS_REQ));
                    write_reg(acdc_pkg::REG_AC_MIN_HIGH, 64'(acdc_pkg::RST_AC_MIN_HIGH));
                    write_reg(acdc_pkg::REG_DC_LOW_PERCENT,
                              64'(acdc_pkg::RST_DC_LOW_PERCENT));
                    write_reg(acdc_pkg::REG_DC_HIGH_PERCENT,
                              64'(acdc_pkg::RST_DC_HIGH_PERCENT));
                end
                2: begin
                    stall_pct = 10;
                    write_reg(acdc_pkg::REG_MODE_MASK,       64'($urandom_range(0, 255)));
                    write_reg(acdc_pkg::REG_PERIOD_LENGTHS,  rand_bytes(0, 1));
                    write_reg(acdc_pkg::REG_TOL_PERCENTS,    rand_bytes(0, 255));
                    write_reg(acdc_pkg::REG_PERIODS_REQ,     64'd255);
                    write_reg(acdc_pkg::REG_AC_MIN_HIGH,     64'($urandom_range(0, 2)));
                    write_reg(acdc_pkg::REG_DC_LOW_PERCENT,  64'($urandom_range(0, 100)));
                    write_reg(acdc_pkg::REG_DC_HIGH_PERCENT, 64'($urandom_range(0, 100)));
                end
                3: begin
                    stall_pct = 0;
                    write_reg(acdc_pkg::REG_MODE_MASK,       64'hF0);
                    write_reg(acdc_pkg::REG_PERIOD_LENGTHS,  64'h0001_03FF_0001_02FF);
                    write_reg(acdc_pkg::REG_TOL_PERCENTS,    64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(acdc_pkg::REG_PERIODS_REQ,     64'd1);
                    write_reg(acdc_pkg::REG_AC_MIN_HIGH,     64'hFF);
                    write_reg(acdc_pkg::REG_DC_LOW_PERCENT,  64'd100);
                    write_reg(acdc_pkg::REG_DC_HIGH_PERCENT, 64'd0);
                end
                default: begin
                    stall_pct = (p == 1) ? 40 : 0;
                    write_reg(acdc_pkg::REG_MODE_MASK,       64'($urandom_range(0, 255)));
                    write_reg(acdc_pkg::REG_PERIOD_LENGTHS,  rand_bytes(1, 6));
                    write_reg(acdc_pkg::REG_TOL_PERCENTS,    rand_bytes(0, 60));
                    write_reg(acdc_pkg::REG_PERIODS_REQ,     64'($urandom_range(1, 3)));
                    write_reg(acdc_pkg::REG_AC_MIN_HIGH,     64'($urandom_range(0, 3)));
                    write_reg(acdc_pkg::REG_DC_LOW_PERCENT,  64'($urandom_range(0, 100)));
                    write_reg(acdc_pkg::REG_DC_HIGH_PERCENT, 64'($urandom_range(0, 100)));
                end
            endcase
            cfg_valid <= 1'b0;
            repeat (phase_items[p]) offer_tick(next_scan_pins(), 1'b0, '0);
        end

        drain_results();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/acdc_pkg.sv
sv/acdc_thresh.sv
sv/acdc_lane.sv
sv/acdc_merge.sv
sv/ac_dc_input_qualifier_core.sv
bench/ac_dc_input_qualifier_core_tb.sv
